>>> hw/rtl/connection_tracking_table_macros.svh
// assertion macros shared by the connection tracking table rtl
// no dependencies
`ifndef CONNECTION_TRACKING_TABLE_MACROS_SVH
`define CONNECTION_TRACKING_TABLE_MACROS_SVH

// same-cycle implication
`define CTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/ctt_pkg.sv
// types, codes and constants of the connection tracking table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctt_pkg;

    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
    localparam int          TAG_W     = 296;
    localparam logic [31:0] REFRESH_RESET = 32'd1000000000;

    typedef enum logic [2:0] {
        OC_SKIPPED     = 3'd0,
        OC_INSERTED    = 3'd1,
        OC_OVERWRITTEN = 3'd2,
        OC_REFRESHED   = 3'd3,
        OC_HIT_SAME    = 3'd4,
        OC_MISS        = 3'd5
    } outcome_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_P0,
        MUL_P1,
        MUL_P2,
        MUL_IDX
    } mul_op_t;

    typedef struct packed {
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  proto_number;
        logic        syn_flag;
        logic [63:0] now_ns;
    } item_t;

    typedef struct packed {
        outcome_t outcome;
        logic     evicted;
    } result_t;

    typedef struct packed {
        logic    load_item;
        logic    fold;
        mul_op_t mul_op;
        logic    compare;
        logic    commit;
        logic    clear_write;
        logic    res_skip;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic clear_last;
    } status_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ctt_datapath.sv
// datapath: tuple register, hash with shared multiplier, set memory, compare and write-back
// depends on ctt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctt_datapath #(
    parameter int TABLE_SETS = 1024,
    parameter int TABLE_WAYS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctt_pkg::item_t    item,
    input  wire logic              tracking_enable,
    input  wire logic [31:0]       refresh_interval_ns,
    input  wire ctt_pkg::cmd_t     cmd,
    output ctt_pkg::status_t       status,
    output ctt_pkg::result_t       result
);
    import ctt_pkg::*;

    localparam int RW = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int IW = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;

    item_t item_reg;
    logic [63:0] x_reg;
    logic [63:0] p0_reg;
    logic [31:0] hi_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] clr_reg;
    result_t result_reg;

    logic [TABLE_WAYS-1:0]            mem_valid [TABLE_SETS];
    logic [TABLE_WAYS-1:0][TAG_W-1:0] mem_tag   [TABLE_SETS];
    logic [TABLE_WAYS-1:0][63:0]      mem_time  [TABLE_SETS];
    logic [TABLE_WAYS-1:0][RW-1:0]    mem_rank  [TABLE_SETS];

    logic [TABLE_WAYS-1:0]            rd_valid_reg;
    logic [TABLE_WAYS-1:0][TAG_W-1:0] rd_tag_reg;
    logic [TABLE_WAYS-1:0][63:0]      rd_time_reg;
    logic [TABLE_WAYS-1:0][RW-1:0]    rd_rank_reg;

    logic          hit_reg;
    logic [RW-1:0] hit_way_reg;
    logic [RW-1:0] victim_reg;
    logic          evict_reg;
    logic [TABLE_WAYS-1:0] gt_reg;

    logic [39:0]      pp;
    logic [TAG_W-1:0] key;
    logic [63:0]      fold_x;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;

    logic          hit_c;
    logic [RW-1:0] hit_way_c;
    logic [RW-1:0] victim_c;
    logic [TABLE_WAYS-1:0] gt_c;

    logic [RW-1:0] sel_way;
    logic [RW-1:0] rank_sel;
    logic          is_tcp;
    logic          we;
    outcome_t      oc;
    logic          ev;
    logic [TABLE_WAYS-1:0]            wr_valid;
    logic [TABLE_WAYS-1:0][TAG_W-1:0] wr_tag;
    logic [TABLE_WAYS-1:0][63:0]      wr_time;
    logic [TABLE_WAYS-1:0][RW-1:0]    wr_rank;
    logic [TABLE_WAYS-1:0][RW-1:0]    init_rank;

    assign pp  = {item_reg.source_port, item_reg.dest_port, item_reg.proto_number};
    assign key = {item_reg.src_addr_high, item_reg.src_addr_low,
                  item_reg.dst_addr_high, item_reg.dst_addr_low, pp};
    assign fold_x = item_reg.src_addr_high ^ rotl64(item_reg.src_addr_low, 13)
                  ^ rotl64(item_reg.dst_addr_high, 29) ^ rotl64(item_reg.dst_addr_low, 43)
                  ^ {24'd0, pp};

    assign status.skip = !tracking_enable || (item_reg.source_port == 16'd0)
                       || (item_reg.dest_port == 16'd0)
                       || ((item_reg.proto_number != PROTO_TCP)
                           && (item_reg.proto_number != PROTO_UDP));
    assign status.clear_last = (clr_reg == IW'(TABLE_SETS - 1));

    always_comb
    begin
        case (cmd.mul_op)
            MUL_P0:
            begin
                mul_a = x_reg[31:0];
                mul_b = HASH_MULT[31:0];
            end
            MUL_P1:
            begin
                mul_a = x_reg[63:32];
                mul_b = HASH_MULT[31:0];
            end
            MUL_P2:
            begin
                mul_a = x_reg[31:0];
                mul_b = HASH_MULT[63:32];
            end
            MUL_IDX:
            begin
                mul_a = hi_reg;
                mul_b = 32'(TABLE_SETS);
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.fold)
        begin
            x_reg <= fold_x;
        end
        case (cmd.mul_op)
            MUL_P0:  p0_reg  <= prod;
            MUL_P1:  hi_reg  <= p0_reg[63:32] + prod[31:0];
            MUL_P2:  hi_reg  <= hi_reg + prod[31:0];
            MUL_IDX: idx_reg <= prod[32 +: IW];
            default: ;
        endcase
    end

    // set read, data registered
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= mem_valid[idx_reg];
        rd_tag_reg   <= mem_tag[idx_reg];
        rd_time_reg  <= mem_time[idx_reg];
        rd_rank_reg  <= mem_rank[idx_reg];
    end

    // compare and victim choice
    always_comb
    begin
        hit_c     = 1'b0;
        hit_way_c = '0;
        victim_c  = '0;
        for (int w = TABLE_WAYS - 1; w >= 0; w--)
        begin
            gt_c[w] = (item_reg.now_ns - rd_time_reg[w]) > {32'd0, refresh_interval_ns};
            if (rd_rank_reg[w] == RW'(TABLE_WAYS - 1))
            begin
                victim_c = RW'(w);
            end
        end
        for (int w = TABLE_WAYS - 1; w >= 0; w--)
        begin
            if (rd_valid_reg[w] && (rd_tag_reg[w] == key))
            begin
                hit_c     = 1'b1;
                hit_way_c = RW'(w);
            end
            if (!rd_valid_reg[w])
            begin
                victim_c = RW'(w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            hit_reg     <= hit_c;
            hit_way_reg <= hit_way_c;
            victim_reg  <= victim_c;
            evict_reg   <= &rd_valid_reg;
            gt_reg      <= gt_c;
        end
    end

    // write-back row
    always_comb
    begin
        sel_way  = hit_reg ? hit_way_reg : victim_reg;
        rank_sel = rd_rank_reg[sel_way];
        is_tcp   = (item_reg.proto_number == PROTO_TCP);
        wr_valid = rd_valid_reg;
        wr_tag   = rd_tag_reg;
        wr_time  = rd_time_reg;
        we       = 1'b0;
        oc       = OC_MISS;
        ev       = 1'b0;
        for (int w = 0; w < TABLE_WAYS; w++)
        begin
            init_rank[w] = RW'(w);
            if (RW'(w) == sel_way)
            begin
                wr_rank[w] = '0;
            end
            else if (rd_rank_reg[w] < rank_sel)
            begin
                wr_rank[w] = rd_rank_reg[w] + 1'b1;
            end
            else
            begin
                wr_rank[w] = rd_rank_reg[w];
            end
        end
        if (hit_reg)
        begin
            we = 1'b1;
            if (is_tcp && item_reg.syn_flag)
            begin
                wr_time[sel_way] = item_reg.now_ns;
                oc = OC_OVERWRITTEN;
            end
            else if (gt_reg[sel_way])
            begin
                wr_time[sel_way] = item_reg.now_ns;
                oc = OC_REFRESHED;
            end
            else
            begin
                oc = OC_HIT_SAME;
            end
        end
        else if (is_tcp && !item_reg.syn_flag)
        begin
            oc = OC_MISS;
        end
        else
        begin
            we = 1'b1;
            wr_valid[sel_way] = 1'b1;
            wr_tag[sel_way]   = key;
            wr_time[sel_way]  = item_reg.now_ns;
            oc = OC_INSERTED;
            ev = evict_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_write)
        begin
            mem_valid[clr_reg] <= '0;
            mem_rank[clr_reg]  <= init_rank;
        end
        else if (cmd.commit && we)
        begin
            mem_valid[idx_reg] <= wr_valid;
            mem_tag[idx_reg]   <= wr_tag;
            mem_time[idx_reg]  <= wr_time;
            mem_rank[idx_reg]  <= wr_rank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_write)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_skip)
        begin
            result_reg.outcome <= OC_SKIPPED;
            result_reg.evicted <= 1'b0;
        end
        else if (cmd.commit)
        begin
            result_reg.outcome <= oc;
            result_reg.evicted <= ev;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ctt_ctrl.sv
// controller: clearing pass, hash steps, read, compare and write-back sequencing
// depends on ctt_pkg and connection_tracking_table_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "connection_tracking_table_macros.svh"

module ctt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ctt_pkg::status_t  status,
    output ctt_pkg::cmd_t          cmd,
    output logic                   busy,
    output logic                   done
);
    import ctt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FOLD,
        S_M0,
        S_M1,
        S_M2,
        S_MIDX,
        S_READ,
        S_CMP,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_FOLD;
                    busy_next     = 1'b1;
                end
            end
            S_FOLD:
            begin
                if (status.skip)
                begin
                    cmd.res_skip = 1'b1;
                    state_next   = S_IDLE;
                    busy_next    = 1'b0;
                    done_next    = 1'b1;
                end
                else
                begin
                    cmd.fold   = 1'b1;
                    state_next = S_M0;
                end
            end
            S_M0:
            begin
                cmd.mul_op = MUL_P0;
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd.mul_op = MUL_P1;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.mul_op = MUL_P2;
                state_next = S_MIDX;
            end
            S_MIDX:
            begin
                cmd.mul_op = MUL_IDX;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `CTT_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `CTT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy_reg, busy_reg)
    `CTT_ASSERT_IMPL(a_idle_free, clk, rst_n, state_reg == S_IDLE, !busy_reg)
    `CTT_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE)

endmodule

`default_nettype wire

>>> hw/rtl/connection_tracking_table.sv
// top level of the connection tracking table: config registers, controller, datapath
// depends on ctt_pkg, ctt_ctrl and ctt_datapath
`timescale 1ns / 1ps
`default_nettype none

// usage
// - command channel: an item beat is taken when start is high and busy is low
// - result channel: done is high for one cycle with outcome and evicted on result;
//   the receiver cannot stall, so every result must be taken in that cycle
// - apb port: byte address 0 is tracking_enable, 4 is refresh_interval_ns;
//   write only while busy is low and no result is pending
// - sequencing: a skipped item ends at the fold step, any other item runs through
//   the fold, four steps of the shared 32x32 multiplier, the registered set read,
//   the compare and the write-back; busy falls when done rises, so a new item is
//   taken only once the last one is done
// - reset: busy stays high while a clearing pass walks the set memory, one set a
//   cycle, marking ways invalid and loading lru ranks
// - config registers reset to tracking off and a 1 s refresh interval
module connection_tracking_table #(
    parameter int TABLE_SETS = 1024,
    parameter int TABLE_WAYS = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire ctt_pkg::item_t   item,
    output logic                  busy,
    output logic                  done,
    output ctt_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ctt_pkg::*;

    logic        tracking_enable_reg;
    logic [31:0] refresh_interval_reg;
    cmd_t        cmd;
    status_t     status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_enable_reg  <= 1'b0;
            refresh_interval_reg <= REFRESH_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
            begin
                refresh_interval_reg <= pwdata;
            end
            else
            begin
                tracking_enable_reg <= pwdata[0];
            end
        end
    end

    assign prdata = paddr[2] ? refresh_interval_reg : {31'd0, tracking_enable_reg};

    ctt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ctt_datapath #(
        .TABLE_SETS (TABLE_SETS),
        .TABLE_WAYS (TABLE_WAYS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item                (item),
        .tracking_enable     (tracking_enable_reg),
        .refresh_interval_ns (refresh_interval_reg),
        .cmd                 (cmd),
        .status              (status),
        .result              (result)
    );

endmodule

`default_nettype wire
